>>> rtl/core/mbr_pkg.sv
// Shared types and constants for the MSB-first bit reader.
package mbr_pkg;

  localparam int BYTE_W        = 8;
  localparam int VALUE_W       = 32;
  localparam int POS_PORT_W    = 13;
  localparam int KIND_W        = 3;
  localparam int CNT_W         = 6;
  localparam int DISP_W        = 14;
  localparam int OFF_W         = 3;
  localparam int NB_W          = 4;   // bits taken from one byte, 0..8
  localparam int MAX_READ_BITS = 32;

  typedef enum logic [KIND_W-1:0] {
    K_WRITE_BYTE = 3'd0,
    K_SET_POS    = 3'd1,
    K_READ_BITS  = 3'd2,
    K_SKIP_BITS  = 3'd3,
    K_ALIGN      = 3'd4,
    K_SEEK       = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_RANGE     = 2'd1,
    ST_READ_ONLY = 2'd2
  } status_t;

  // Control from the sequencer to the digit accumulator.
  typedef struct packed {
    logic            clear;
    logic            shift;
    logic [OFF_W-1:0] start;  // first bit of the byte to take, from the MSB end
    logic [NB_W-1:0]  nb;     // number of bits to take
  } acc_ctl_t;

endpackage

>>> rtl/core/mbr_byte_ram.sv
// Byte store: one write port, one read port with registered data.
module mbr_byte_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12
) (
  input  logic                      clk,
  input  logic                      we,
  input  logic [AW-1:0]             waddr,
  input  logic [mbr_pkg::BYTE_W-1:0] wdata,
  input  logic [AW-1:0]             raddr,
  output logic [mbr_pkg::BYTE_W-1:0] rdata
);
  import mbr_pkg::*;

  logic [BYTE_W-1:0] mem [DEPTH];
  logic [BYTE_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/core/mbr_digit_acc.sv
// Value accumulator: appends the read bits taken from one byte per cycle while shift is set.
module mbr_digit_acc (
  input  logic                       clk,
  input  mbr_pkg::acc_ctl_t          ctl,
  input  logic [mbr_pkg::BYTE_W-1:0]  byte_in,
  output logic [mbr_pkg::VALUE_W-1:0] value
);
  import mbr_pkg::*;

  logic [VALUE_W-1:0] value_r;
  logic [VALUE_W-1:0] value_nxt;
  logic [BYTE_W-1:0]  lead;
  logic [BYTE_W-1:0]  field;

  // drop the bits before start, then keep the top nb bits right aligned
  always_comb begin
    lead      = byte_in << ctl.start;
    field     = lead >> (NB_W'(BYTE_W) - ctl.nb);
    value_nxt = (value_r << ctl.nb) | VALUE_W'(field);
  end

  always_ff @(posedge clk) begin
    if (ctl.clear) begin
      value_r <= '0;
    end else if (ctl.shift) begin
      value_r <= value_nxt;
    end
  end

  assign value = value_r;

endmodule

>>> rtl/core/msb_first_bit_reader.sv
// Top level: byte store read as an MSB-first bitstream, one operation per transaction.
//
//  channel  ports                                   handshake
//  -------  --------------------------------------  ----------------------------
//  input    in_kind, in_byte_value, in_bit_count,   start && !busy
//           in_byte_offset, in_new_position
//  result   out_value, out_position, out_bit_offset, out_valid, one cycle wide
//           out_used_size, out_status
//  config   cfg_read_only                           cfg_valid && cfg_ready
//
// Sequence: every operation passes from accept through the execute state back to
// idle, where it raises the strobe. A read_bits of n > 0 bits that passes its range
// checks also takes a shift state per byte it touches: the single registered read
// port of the byte store delivers one byte per cycle to the digit accumulator.
// Reset (rst_n low, synchronous) clears position, bit offset, size and read_only;
// the byte store holds no reset state. The receiver cannot stall: out_valid is a
// one-cycle strobe, and the strobe cycle already accepts the next transaction.
module msb_first_bit_reader #(
  parameter int STORE_BYTES = 4096
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input channel
  input  logic                             start,
  output logic                             busy,
  input  logic [mbr_pkg::KIND_W-1:0]       in_kind,
  input  logic [mbr_pkg::BYTE_W-1:0]       in_byte_value,
  input  logic [mbr_pkg::CNT_W-1:0]        in_bit_count,
  input  logic signed [mbr_pkg::DISP_W-1:0] in_byte_offset,
  input  logic [mbr_pkg::POS_PORT_W-1:0]   in_new_position,
  // result channel
  output logic                             out_valid,
  output logic [mbr_pkg::VALUE_W-1:0]      out_value,
  output logic [mbr_pkg::POS_PORT_W-1:0]   out_position,
  output logic [mbr_pkg::OFF_W-1:0]        out_bit_offset,
  output logic [mbr_pkg::POS_PORT_W-1:0]   out_used_size,
  output logic [1:0]                       out_status,
  // configuration
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             cfg_read_only
);
  import mbr_pkg::*;

  // position width covers the store size and never drops below the port width
  localparam int POS_NEED = $clog2(STORE_BYTES + 1);
  localparam int POS_W    = (POS_NEED > POS_PORT_W) ? POS_NEED : POS_PORT_W;
  localparam int AW       = $clog2(STORE_BYTES);
  localparam int CUR_W    = POS_W + OFF_W;   // bit cursor
  localparam int SUM_W    = CUR_W + 1;
  localparam int TW       = POS_W + 2;       // signed seek target

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT
  } state_t;

  state_t state_r;

  // architectural state
  logic [POS_W-1:0] pos_r;
  logic [OFF_W-1:0] off_r;
  logic [POS_W-1:0] size_r;
  logic             read_only_r;

  // latched command
  logic [KIND_W-1:0]        cmd_kind_r;
  logic [BYTE_W-1:0]        cmd_byte_r;
  logic [CNT_W-1:0]         cmd_count_r;
  logic signed [DISP_W-1:0] cmd_disp_r;
  logic [POS_PORT_W-1:0]    cmd_newpos_r;

  // read sequencing
  logic [AW-1:0]    addr_r;
  logic [CNT_W-1:0] rem_r;
  logic [OFF_W-1:0] start_r;
  status_t          status_r;
  logic             out_valid_r;

  // execute-cycle decisions
  logic [POS_W-1:0] pos_nxt;
  logic [OFF_W-1:0] off_nxt;
  logic [POS_W-1:0] size_nxt;
  status_t          status_nxt;
  logic             mem_we;
  logic             go_shift;

  logic [SUM_W-1:0] cur_sum;
  logic [SUM_W-1:0] end_bits;
  logic             past_end;
  logic             al_need;
  logic             al_fail;
  logic [TW-1:0]    tgt;
  logic [POS_W-1:0] pos_inc;

  // shift-cycle digit control
  logic [NB_W-1:0]  avail;
  logic [NB_W-1:0]  nb;
  logic [CNT_W-1:0] rem_nxt;

  logic [AW-1:0]      rd_addr;
  logic [BYTE_W-1:0]  rd_data;
  logic [VALUE_W-1:0] acc_value;
  acc_ctl_t           acc_ctl;

  wire accept = start && !busy;

  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // ---------------------------------------------------------------------------
  // Execute: all range checks and updates of position, offset and size happen in
  // the cycle after accept; a read then only streams bytes into the accumulator.
  // ---------------------------------------------------------------------------
  always_comb begin
    cur_sum  = SUM_W'({pos_r, off_r}) + SUM_W'(cmd_count_r);
    end_bits = SUM_W'({size_r, {OFF_W{1'b0}}});
    past_end = cur_sum > end_bits;
    al_need  = (off_r != '0);
    al_fail  = al_need && (pos_r >= size_r);
    // seek target: aligned position plus signed displacement, one adder
    tgt      = TW'({2'b00, pos_r}) + TW'(cmd_disp_r) + TW'(al_need);
    pos_inc  = pos_r + POS_W'(1);

    pos_nxt    = pos_r;
    off_nxt    = off_r;
    size_nxt   = size_r;
    status_nxt = ST_OK;
    mem_we     = 1'b0;
    go_shift   = 1'b0;

    case (cmd_kind_r)
      K_WRITE_BYTE: begin
        if (read_only_r) begin
          status_nxt = ST_READ_ONLY;
        end else if (pos_r >= POS_W'(STORE_BYTES)) begin
          status_nxt = ST_RANGE;
        end else begin
          mem_we  = 1'b1;
          pos_nxt = pos_inc;
          if (pos_inc > size_r) begin
            size_nxt = pos_inc;
          end
        end
      end
      K_SET_POS: begin
        if (POS_W'(cmd_newpos_r) > size_r) begin
          status_nxt = ST_RANGE;
        end else begin
          pos_nxt = POS_W'(cmd_newpos_r);
          off_nxt = '0;
        end
      end
      K_READ_BITS, K_SKIP_BITS: begin
        if (((cmd_kind_r == K_READ_BITS) && (cmd_count_r > CNT_W'(MAX_READ_BITS)))
            || past_end) begin
          status_nxt = ST_RANGE;
        end else begin
          pos_nxt  = cur_sum[SUM_W-2:OFF_W];
          off_nxt  = cur_sum[OFF_W-1:0];
          go_shift = (cmd_kind_r == K_READ_BITS) && (cmd_count_r != '0);
        end
      end
      K_ALIGN: begin
        if (al_fail) begin
          status_nxt = ST_RANGE;
        end else if (al_need) begin
          pos_nxt = pos_inc;
          off_nxt = '0;
        end
      end
      K_SEEK: begin
        if (al_fail || tgt[TW-1] || (tgt[TW-2:0] > {1'b0, size_r})) begin
          status_nxt = ST_RANGE;
        end else begin
          pos_nxt = tgt[POS_W-1:0];
          off_nxt = '0;
        end
      end
      default: begin
        status_nxt = ST_RANGE;
      end
    endcase
  end

  // ---------------------------------------------------------------------------
  // Shift: take the bits of one byte per cycle, up to the end of the byte or
  // the end of the request, whichever comes first.
  // ---------------------------------------------------------------------------
  always_comb begin
    avail   = NB_W'(BYTE_W) - NB_W'(start_r);
    nb      = (CNT_W'(avail) < rem_r) ? avail : rem_r[NB_W-1:0];
    rem_nxt = rem_r - CNT_W'(nb);
  end

  // the first byte is fetched from the current position during execute
  assign rd_addr = (state_r == S_SHIFT) ? addr_r : pos_r[AW-1:0];

  always_comb begin
    acc_ctl.clear = (state_r == S_EXEC);
    acc_ctl.shift = (state_r == S_SHIFT);
    acc_ctl.start = start_r;
    acc_ctl.nb    = nb;
  end

  // ---------------------------------------------------------------------------
  // Sequencer: state and registered outputs
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      pos_r       <= '0;
      off_r       <= '0;
      size_r      <= '0;
      read_only_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        read_only_r <= cfg_read_only;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          pos_r    <= pos_nxt;
          off_r    <= off_nxt;
          size_r   <= size_nxt;
          status_r <= status_nxt;
          addr_r   <= pos_r[AW-1:0] + AW'(1);
          rem_r    <= cmd_count_r;
          start_r  <= off_r;
          if (go_shift) begin
            state_r <= S_SHIFT;
          end else begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        S_SHIFT: begin
          rem_r   <= rem_nxt;
          start_r <= '0;
          addr_r  <= addr_r + AW'(1);
          if (rem_nxt == '0) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  // command capture, payload only
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_kind_r   <= in_kind;
      cmd_byte_r   <= in_byte_value;
      cmd_count_r  <= in_bit_count;
      cmd_disp_r   <= in_byte_offset;
      cmd_newpos_r <= in_new_position;
    end
  end

  mbr_byte_ram #(
    .DEPTH (STORE_BYTES),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    ((state_r == S_EXEC) && mem_we),
    .waddr (pos_r[AW-1:0]),
    .wdata (cmd_byte_r),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  mbr_digit_acc u_acc (
    .clk     (clk),
    .ctl     (acc_ctl),
    .byte_in (rd_data),
    .value   (acc_value)
  );

  assign out_valid      = out_valid_r;
  assign out_value      = acc_value;
  assign out_position   = pos_r[POS_PORT_W-1:0];
  assign out_bit_offset = off_r;
  assign out_used_size  = size_r[POS_PORT_W-1:0];
  assign out_status     = status_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted transaction did not enter execute");

  a_strobe_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (state_r == S_IDLE))
    else $error("result strobe outside idle");

  a_pos_in_size: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= size_r)
    else $error("byte position beyond used size");

  a_shift_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> (rem_r != '0))
    else $error("shift cycle with no bits left");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |-> (out_value == '0))
    else $error("failed operation returned nonzero value");

endmodule
